// File: rtl/pjbmap_pkg.sv
// ----------------------------------------------------------------------------
// pjbmap_pkg
// Shared widths, register indexes, reset values and corner angle sets of the
// pixel to joint angle bilinear map.
// ----------------------------------------------------------------------------
package pjbmap_pkg;

   localparam int FRACTION_BITS       = 16;
   localparam int ANGLE_FRACTION_BITS = 8;

   localparam int COORD_W     = 11;
   localparam int MAG_W       = COORD_W + 1;
   localparam int DIFF_W      = COORD_W + 2;
   localparam int ANGLE_W     = 16;
   localparam int JOINTS      = 4;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TOP_LEFT_ROW     = 4'd0,
      CSR_TOP_LEFT_COL     = 4'd1,
      CSR_TOP_RIGHT_ROW    = 4'd2,
      CSR_TOP_RIGHT_COL    = 4'd3,
      CSR_BOTTOM_LEFT_ROW  = 4'd4,
      CSR_BOTTOM_LEFT_COL  = 4'd5,
      CSR_BOTTOM_RIGHT_ROW = 4'd6,
      CSR_BOTTOM_RIGHT_COL = 4'd7
   } csr_index_type;

   localparam logic [COORD_W-1:0] RST_TOP_LEFT_ROW     = 11'd253;
   localparam logic [COORD_W-1:0] RST_TOP_LEFT_COL     = 11'd876;
   localparam logic [COORD_W-1:0] RST_TOP_RIGHT_ROW    = 11'd253;
   localparam logic [COORD_W-1:0] RST_TOP_RIGHT_COL    = 11'd1171;
   localparam logic [COORD_W-1:0] RST_BOTTOM_LEFT_ROW  = 11'd542;
   localparam logic [COORD_W-1:0] RST_BOTTOM_LEFT_COL  = 11'd860;
   localparam logic [COORD_W-1:0] RST_BOTTOM_RIGHT_ROW = 11'd542;
   localparam logic [COORD_W-1:0] RST_BOTTOM_RIGHT_COL = 11'd1215;

   // Corner angle sets in whole degrees, element 0 is the base joint.
   localparam logic [JOINTS-1:0][7:0] CORNER_TL = {8'd140, 8'd115, 8'd154, 8'd97};
   localparam logic [JOINTS-1:0][7:0] CORNER_TR = {8'd140, 8'd115, 8'd154, 8'd81};
   localparam logic [JOINTS-1:0][7:0] CORNER_BL = {8'd150, 8'd150, 8'd123, 8'd102};
   localparam logic [JOINTS-1:0][7:0] CORNER_BR = {8'd150, 8'd150, 8'd123, 8'd78};

endpackage

// File: rtl/pjbmap_if.sv
// ----------------------------------------------------------------------------
// pjbmap_if
// Valid/ready channel interfaces of the bilinear map: pixel requests, angle
// responses and calibration register writes.
// ----------------------------------------------------------------------------
interface pjbmap_req_if;
   logic                              valid;
   logic                              ready;
   logic [pjbmap_pkg::COORD_W-1:0]    pixel_row;
   logic [pjbmap_pkg::COORD_W-1:0]    pixel_col;

   modport source (output valid, output pixel_row, output pixel_col, input ready);
   modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface pjbmap_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pjbmap_pkg::ANGLE_W-1:0]    base_angle;
   logic [pjbmap_pkg::ANGLE_W-1:0]    shoulder_angle;
   logic [pjbmap_pkg::ANGLE_W-1:0]    elbow_angle;
   logic [pjbmap_pkg::ANGLE_W-1:0]    wrist_angle;
   logic                              span_degenerate;

   modport source (output valid, output base_angle, output shoulder_angle,
                   output elbow_angle, output wrist_angle, output span_degenerate,
                   input ready);
   modport sink   (input valid, input base_angle, input shoulder_angle,
                   input elbow_angle, input wrist_angle, input span_degenerate,
                   output ready);
endinterface

interface pjbmap_csr_if;
   logic                                valid;
   logic                                ready;
   logic [pjbmap_pkg::CSR_INDEX_W-1:0]  index;
   logic [pjbmap_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/pixel_to_joint_angle_bilinear_map_core.sv
// ----------------------------------------------------------------------------
// pixel_to_joint_angle_bilinear_map_core
// Maps a pixel position to four joint angles by bilinear interpolation
// between fixed corner angle sets placed at calibrated pixel corners.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction on req_bus carries one pixel row and column. Each
// request yields exactly one response transaction on rsp_bus with the four
// joint angles in unsigned Q8 fixed point and a flag that reports a zero
// calibration span. Eight calibration registers are written over csr_bus,
// which is always ready; writes to indexes above seven are dropped.
// The user must write the registers only while no request is in flight;
// the block itself does not enforce it. A request passes one classify stage,
// one stage per quotient bit of the divider, then the weight, product and
// rounding stages. One request is accepted per cycle while the response
// side takes transactions.
// Reset empties the pipeline and restores the calibration registers to
// their default corners. When the receiver stalls, the whole pipeline holds
// and req_bus.ready drops until the response register is taken.
// ----------------------------------------------------------------------------
module pixel_to_joint_angle_bilinear_map_core #(
   parameter int FRACTION_BITS       = pjbmap_pkg::FRACTION_BITS,
   parameter int ANGLE_FRACTION_BITS = pjbmap_pkg::ANGLE_FRACTION_BITS
) (
   input  logic          clock,
   input  logic          reset,
   pjbmap_req_if.sink    req_bus,
   pjbmap_rsp_if.source  rsp_bus,
   pjbmap_csr_if.sink    csr_bus
);

   localparam int CW = pjbmap_pkg::COORD_W;
   localparam int MW = pjbmap_pkg::MAG_W;
   localparam int DW = pjbmap_pkg::DIFF_W;

   logic [CW-1:0]          tl_row_ff, tl_col_ff, tr_row_ff, tr_col_ff;
   logic [CW-1:0]          bl_row_ff, bl_col_ff, br_row_ff, br_col_ff;
   logic [CW-1:0]          csr_value;
   logic [MW-1:0]          top_sum, bot_sum, left_sum, right_sum;
   logic signed [DW-1:0]   num_v, den_v, num_u, den_u;
   logic                   advance;
   logic                   div_valid;
   logic [FRACTION_BITS:0] frac_v, frac_u;
   logic                   div_degenerate;

   assign csr_bus.ready = 1'b1;
   assign csr_value     = csr_bus.data[CW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         tl_row_ff <= pjbmap_pkg::RST_TOP_LEFT_ROW;
         tl_col_ff <= pjbmap_pkg::RST_TOP_LEFT_COL;
         tr_row_ff <= pjbmap_pkg::RST_TOP_RIGHT_ROW;
         tr_col_ff <= pjbmap_pkg::RST_TOP_RIGHT_COL;
         bl_row_ff <= pjbmap_pkg::RST_BOTTOM_LEFT_ROW;
         bl_col_ff <= pjbmap_pkg::RST_BOTTOM_LEFT_COL;
         br_row_ff <= pjbmap_pkg::RST_BOTTOM_RIGHT_ROW;
         br_col_ff <= pjbmap_pkg::RST_BOTTOM_RIGHT_COL;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            pjbmap_pkg::CSR_TOP_LEFT_ROW:     tl_row_ff <= csr_value;
            pjbmap_pkg::CSR_TOP_LEFT_COL:     tl_col_ff <= csr_value;
            pjbmap_pkg::CSR_TOP_RIGHT_ROW:    tr_row_ff <= csr_value;
            pjbmap_pkg::CSR_TOP_RIGHT_COL:    tr_col_ff <= csr_value;
            pjbmap_pkg::CSR_BOTTOM_LEFT_ROW:  bl_row_ff <= csr_value;
            pjbmap_pkg::CSR_BOTTOM_LEFT_COL:  bl_col_ff <= csr_value;
            pjbmap_pkg::CSR_BOTTOM_RIGHT_ROW: br_row_ff <= csr_value;
            pjbmap_pkg::CSR_BOTTOM_RIGHT_COL: br_col_ff <= csr_value;
            default: ;
         endcase
      end
   end

   assign top_sum   = {1'b0, tl_row_ff} + {1'b0, tr_row_ff};
   assign bot_sum   = {1'b0, bl_row_ff} + {1'b0, br_row_ff};
   assign left_sum  = {1'b0, tl_col_ff} + {1'b0, bl_col_ff};
   assign right_sum = {1'b0, tr_col_ff} + {1'b0, br_col_ff};

   assign num_v = $signed({1'b0, req_bus.pixel_row, 1'b0} - {1'b0, top_sum});
   assign den_v = $signed({1'b0, bot_sum} - {1'b0, top_sum});
   assign num_u = $signed({1'b0, req_bus.pixel_col, 1'b0} - {1'b0, left_sum});
   assign den_u = $signed({1'b0, right_sum} - {1'b0, left_sum});

   assign advance       = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = advance;

   pjbmap_frac_div #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_frac_div (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .in_valid   (req_bus.valid),
      .num_v      (num_v),
      .den_v      (den_v),
      .num_u      (num_u),
      .den_u      (den_u),
      .out_valid  (div_valid),
      .frac_v     (frac_v),
      .frac_u     (frac_u),
      .degenerate (div_degenerate)
   );

   pjbmap_blend #(
      .FRACTION_BITS       (FRACTION_BITS),
      .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
   ) u_blend (
      .clock          (clock),
      .reset          (reset),
      .en             (advance),
      .in_valid       (div_valid),
      .frac_v         (frac_v),
      .frac_u         (frac_u),
      .degenerate_in  (div_degenerate),
      .out_valid      (rsp_bus.valid),
      .base_angle     (rsp_bus.base_angle),
      .shoulder_angle (rsp_bus.shoulder_angle),
      .elbow_angle    (rsp_bus.elbow_angle),
      .wrist_angle    (rsp_bus.wrist_angle),
      .degenerate_out (rsp_bus.span_degenerate)
   );

endmodule

// File: rtl/pjbmap_frac_div.sv
// ----------------------------------------------------------------------------
// pjbmap_frac_div
// Pipelined restoring divider for the two clamped fractions. One register
// stage classifies the operands, then one quotient bit is resolved per stage.
// ----------------------------------------------------------------------------
module pjbmap_frac_div #(
   parameter int FRACTION_BITS = pjbmap_pkg::FRACTION_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic signed [pjbmap_pkg::DIFF_W-1:0]    num_v,
   input  logic signed [pjbmap_pkg::DIFF_W-1:0]    den_v,
   input  logic signed [pjbmap_pkg::DIFF_W-1:0]    num_u,
   input  logic signed [pjbmap_pkg::DIFF_W-1:0]    den_u,
   output logic                                    out_valid,
   output logic [FRACTION_BITS:0]                  frac_v,
   output logic [FRACTION_BITS:0]                  frac_u,
   output logic                                    degenerate
);

   localparam int FB = FRACTION_BITS;
   localparam int MW = pjbmap_pkg::MAG_W;
   localparam int DW = pjbmap_pkg::DIFF_W;

   typedef enum logic [1:0] {
      FRAC_CALC,
      FRAC_ZERO,
      FRAC_ONE,
      FRAC_DEGEN
   } frac_kind_type;

   logic signed [DW-1:0] num_op [0:1];
   logic signed [DW-1:0] den_op [0:1];
   logic [DW-1:0]        num_abs [0:1];
   logic [DW-1:0]        den_abs [0:1];

   logic [MW-1:0]        rem_in  [0:FB][0:1];
   logic [MW-1:0]        rem_ff  [0:FB][0:1];
   logic [MW-1:0]        den_in  [0:FB][0:1];
   logic [MW-1:0]        den_ff  [0:FB][0:1];
   logic [FB-1:0]        quo_in  [0:FB][0:1];
   logic [FB-1:0]        quo_ff  [0:FB][0:1];
   frac_kind_type        kind_in [0:FB][0:1];
   frac_kind_type        kind_ff [0:FB][0:1];
   logic [MW:0]          rem_shl [1:FB][0:1];
   logic [MW:0]          rem_sub [1:FB][0:1];
   logic [FB:0]          valid_ff;
   logic [FB:0]          frac [0:1];

   assign num_op[0] = num_v;
   assign den_op[0] = den_v;
   assign num_op[1] = num_u;
   assign den_op[1] = den_u;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         num_abs[l] = num_op[l][DW-1] ? DW'(-num_op[l]) : DW'(num_op[l]);
         den_abs[l] = den_op[l][DW-1] ? DW'(-den_op[l]) : DW'(den_op[l]);
         rem_in[0][l] = num_abs[l][MW-1:0];
         den_in[0][l] = den_abs[l][MW-1:0];
         quo_in[0][l] = '0;
         if (den_op[l] == '0) begin
            kind_in[0][l] = FRAC_DEGEN;
         end else if ((num_op[l] != '0) && (num_op[l][DW-1] != den_op[l][DW-1])) begin
            kind_in[0][l] = FRAC_ZERO;
         end else if (num_abs[l][MW-1:0] >= den_abs[l][MW-1:0]) begin
            kind_in[0][l] = FRAC_ONE;
         end else begin
            kind_in[0][l] = FRAC_CALC;
         end
      end
      for (int s = 1; s <= FB; s++) begin
         for (int l = 0; l < 2; l++) begin
            rem_shl[s][l] = {rem_ff[s-1][l], 1'b0};
            rem_sub[s][l] = rem_shl[s][l] - {1'b0, den_ff[s-1][l]};
            rem_in[s][l]  = rem_sub[s][l][MW] ? rem_shl[s][l][MW-1:0]
                                              : rem_sub[s][l][MW-1:0];
            quo_in[s][l]  = {quo_ff[s-1][l][FB-2:0], ~rem_sub[s][l][MW]};
            den_in[s][l]  = den_ff[s-1][l];
            kind_in[s][l] = kind_ff[s-1][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[FB-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s <= FB; s++) begin
            for (int l = 0; l < 2; l++) begin
               rem_ff[s][l]  <= rem_in[s][l];
               den_ff[s][l]  <= den_in[s][l];
               quo_ff[s][l]  <= quo_in[s][l];
               kind_ff[s][l] <= kind_in[s][l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         case (kind_ff[FB][l])
            FRAC_CALC: frac[l] = {1'b0, quo_ff[FB][l]};
            FRAC_ONE:  frac[l] = {1'b1, {FB{1'b0}}};
            default:   frac[l] = '0;
         endcase
      end
   end

   assign frac_v     = frac[0];
   assign frac_u     = frac[1];
   assign degenerate = (kind_ff[FB][0] == FRAC_DEGEN) || (kind_ff[FB][1] == FRAC_DEGEN);
   assign out_valid  = valid_ff[FB];

endmodule

// File: rtl/pjbmap_blend.sv
// ----------------------------------------------------------------------------
// pjbmap_blend
// Bilinear blend of the corner angle sets: a weight stage, a stage of
// corner products summed in pairs, and a rounding output register.
// ----------------------------------------------------------------------------
module pjbmap_blend #(
   parameter int FRACTION_BITS       = pjbmap_pkg::FRACTION_BITS,
   parameter int ANGLE_FRACTION_BITS = pjbmap_pkg::ANGLE_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [FRACTION_BITS:0]              frac_v,
   input  logic [FRACTION_BITS:0]              frac_u,
   input  logic                                degenerate_in,
   output logic                                out_valid,
   output logic [pjbmap_pkg::ANGLE_W-1:0]      base_angle,
   output logic [pjbmap_pkg::ANGLE_W-1:0]      shoulder_angle,
   output logic [pjbmap_pkg::ANGLE_W-1:0]      elbow_angle,
   output logic [pjbmap_pkg::ANGLE_W-1:0]      wrist_angle,
   output logic                                degenerate_out
);

   localparam int FB    = FRACTION_BITS;
   localparam int WW    = 2 * FB + 1;
   localparam int PW    = 2 * FB + 2;
   localparam int ACC_W = 2 * FB + 8;
   localparam int SHIFT = 2 * FB - ANGLE_FRACTION_BITS;
   localparam int AW    = pjbmap_pkg::ANGLE_W;
   localparam int NJ    = pjbmap_pkg::JOINTS;

   localparam logic [FB:0]      ONE  = {1'b1, {FB{1'b0}}};
   localparam logic [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (SHIFT - 1);

   logic [FB:0]              comp_u;
   logic [FB:0]              comp_v;
   logic [PW-1:0]            prod [0:3];
   logic [WW-1:0]            weight_in [0:3];
   logic [WW-1:0]            weight_ff [0:3];
   logic [ACC_W-1:0]         pair_a_in [0:NJ-1];
   logic [ACC_W-1:0]         pair_b_in [0:NJ-1];
   logic [ACC_W-1:0]         pair_a_ff [0:NJ-1];
   logic [ACC_W-1:0]         pair_b_ff [0:NJ-1];
   logic [ACC_W-1:0]         acc [0:NJ-1];
   logic [ACC_W-1:0]         scaled [0:NJ-1];
   logic [AW-1:0]            angle_in [0:NJ-1];
   logic [AW-1:0]            angle_ff [0:NJ-1];
   logic                     valid_w_ff;
   logic                     valid_p_ff;
   logic                     valid_o_ff;
   logic                     degen_w_ff;
   logic                     degen_p_ff;
   logic                     degen_o_ff;

   always_comb begin
      comp_u  = ONE - frac_u;
      comp_v  = ONE - frac_v;
      prod[0] = PW'(comp_u) * PW'(comp_v);
      prod[1] = PW'(frac_u) * PW'(comp_v);
      prod[2] = PW'(comp_u) * PW'(frac_v);
      prod[3] = PW'(frac_u) * PW'(frac_v);
      for (int k = 0; k < 4; k++) begin
         weight_in[k] = prod[k][WW-1:0];
      end
   end

   always_comb begin
      for (int j = 0; j < NJ; j++) begin
         pair_a_in[j] = ACC_W'(weight_ff[0]) * ACC_W'(pjbmap_pkg::CORNER_TL[j])
                      + ACC_W'(weight_ff[1]) * ACC_W'(pjbmap_pkg::CORNER_TR[j]);
         pair_b_in[j] = ACC_W'(weight_ff[2]) * ACC_W'(pjbmap_pkg::CORNER_BL[j])
                      + ACC_W'(weight_ff[3]) * ACC_W'(pjbmap_pkg::CORNER_BR[j]);
      end
   end

   always_comb begin
      for (int j = 0; j < NJ; j++) begin
         acc[j]    = pair_a_ff[j] + pair_b_ff[j] + HALF;
         scaled[j] = acc[j] >> SHIFT;
         angle_in[j] = (|scaled[j][ACC_W-1:AW]) ? {AW{1'b1}} : scaled[j][AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_w_ff <= 1'b0;
         valid_p_ff <= 1'b0;
         valid_o_ff <= 1'b0;
      end else if (en) begin
         valid_w_ff <= in_valid;
         valid_p_ff <= valid_w_ff;
         valid_o_ff <= valid_p_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         degen_w_ff <= degenerate_in;
         degen_p_ff <= degen_w_ff;
         degen_o_ff <= degen_p_ff;
         for (int k = 0; k < 4; k++) begin
            weight_ff[k] <= weight_in[k];
         end
         for (int j = 0; j < NJ; j++) begin
            pair_a_ff[j] <= pair_a_in[j];
            pair_b_ff[j] <= pair_b_in[j];
            angle_ff[j]  <= angle_in[j];
         end
      end
   end

   assign out_valid      = valid_o_ff;
   assign base_angle     = angle_ff[0];
   assign shoulder_angle = angle_ff[1];
   assign elbow_angle    = angle_ff[2];
   assign wrist_angle    = angle_ff[3];
   assign degenerate_out = degen_o_ff;

endmodule
